[rtl/core/box_blur_3x3_unit_assert.svh]
// Assertion macros for the box blur unit.
// Each macro takes a label, the clock, the active-low reset, a condition and a check.
// In synthesis builds the macros expand to nothing.
`ifndef BOX_BLUR_3X3_UNIT_ASSERT_SVH
`define BOX_BLUR_3X3_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define BB3_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("box blur check failed");
`define BB3_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("box blur check failed");
`else
`define BB3_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BB3_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/bb3_pkg.sv]
package bb3_pkg;

	localparam int DEF_MAX_WIDTH  = 2048;
	localparam int DEF_MAX_HEIGHT = 4096;
	localparam int RESET_WIDTH    = 640;
	localparam int RESET_HEIGHT   = 480;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 13;
	localparam int FW_REG_W    = 12;
	localparam int FH_REG_W    = 13;

	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	localparam int OUT_ROW_W = 12;
	localparam int OUT_COL_W = 11;
	localparam int PIX_W     = 8;

	// Reciprocal of nine in 16-bit fixed point, plus the rounding half.
	localparam int BLUR_MUL = 7282;
	localparam int BLUR_RND = 32768;

	// Result queue depth; a power of two so the pointers wrap naturally.
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int LEVEL_W    = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic [OUT_ROW_W-1:0] out_row;
		logic [OUT_COL_W-1:0] out_col;
		logic [PIX_W-1:0]     value;
		logic                 last_of_item;
	} result_t;

	// Up to two results enter the queue per cycle, first before second.
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} push_t;

endpackage

[rtl/core/box_blur_3x3_unit.sv]
// The first result of a pixel passes the stage 1 registers and the result queue, then shows
// on out_valid; a second result of that pixel follows it. Throughput: one pixel per cycle
// while in_stall is low, set by the single line store read and write per pixel; the output
// side moves one result per cycle while out_stall is low, so two results need two transfers.
// Reset: position counters, column sums, pipeline and result queue clear; the sizes return
// to 640 by 480; the line store is not cleared and holds undefined data until written.
`include "box_blur_3x3_unit_assert.svh"

module box_blur_3x3_unit
	import bb3_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Configuration write port.
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	// Pixel input channel.
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [PIX_W-1:0]       pixel,
	// Result output channel.
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [OUT_ROW_W-1:0]   out_row,
	output logic [OUT_COL_W-1:0]   out_col,
	output logic [PIX_W-1:0]       value,
	output logic                   last_of_item
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int RST_W = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
	localparam int RST_H = (RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT;
	localparam int LINE_DW = 2 * PIX_W;
	localparam int CSUM_W = 10;
	localparam int WIN_W = 12;
	localparam int PROD_W = 25;

	// The sizes are held as last column and last row, already clamped into range,
	// so the per-pixel tests are plain compares against the counters.
	logic [CW-1:0] w_last_q;
	logic [RW-1:0] h_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_last_q <= CW'(RST_W - 1);
			h_last_q <= RW'(RST_H - 1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH: begin
					if (cfg_data[FW_REG_W-1:0] == '0) begin
						w_last_q <= '0;
					end else if (32'(cfg_data[FW_REG_W-1:0]) > MAX_WIDTH) begin
						w_last_q <= CW'(MAX_WIDTH - 1);
					end else begin
						w_last_q <= CW'(cfg_data[FW_REG_W-1:0] - FW_REG_W'(1));
					end
				end
				REG_FRAME_HEIGHT: begin
					if (cfg_data[FH_REG_W-1:0] == '0) begin
						h_last_q <= '0;
					end else if (32'(cfg_data[FH_REG_W-1:0]) > MAX_HEIGHT) begin
						h_last_q <= RW'(MAX_HEIGHT - 1);
					end else begin
						h_last_q <= RW'(cfg_data[FH_REG_W-1:0] - FH_REG_W'(1));
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Stage 0: the pixel transfer. The line store read is issued at the current
	// column, and the raster counters step on.
	logic               in_xfer;
	logic [CW-1:0]      col_q;
	logic [RW-1:0]      row_q;
	logic [LEVEL_W-1:0] fifo_level;
	logic               valid_s1;

	assign in_xfer = in_valid && !in_stall;

	// The queue must have room for the two results that the pixel in stage 1 may
	// push plus two for a new pixel. This uses registered state only.
	assign in_stall = ({1'b0, fifo_level} + ((valid_s1) ? (LEVEL_W + 1)'(2) : '0))
		> (LEVEL_W + 1)'(FIFO_DEPTH - 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_xfer) begin
			if (col_q >= w_last_q) begin
				col_q <= '0;
				if (row_q >= h_last_q) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + RW'(1);
				end
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Stage 1 registers. When the pixel in stage 1 writes the very entry that the
	// new pixel reads (only in a one-column frame), its write data is forwarded.
	logic [CW-1:0]      col_s1;
	logic [RW-1:0]      row_s1;
	logic [PIX_W-1:0]   pixel_s1;
	logic               fwd_s1;
	logic [LINE_DW-1:0] fwd_data_s1;
	logic [LINE_DW-1:0] line_rd_data;
	logic [LINE_DW-1:0] line_wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_xfer;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			col_s1      <= col_q;
			row_s1      <= row_q;
			pixel_s1    <= pixel;
			fwd_s1      <= valid_s1 && (col_q == col_s1);
			fwd_data_s1 <= line_wr_data;
		end
	end

	// Each line store entry holds the older row in the upper byte and the newer
	// row in the lower byte, so one read and one write move both rows.
	bb3_line_mem #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW),
		.DW    (LINE_DW)
	) u_line_mem (
		.clk     (clk),
		.rd_en   (in_xfer),
		.rd_addr (col_q),
		.rd_data (line_rd_data),
		.wr_en   (valid_s1),
		.wr_addr (col_s1),
		.wr_data (line_wr_data)
	);

	// Stage 1 logic: form the column sum, the window sum and the blurred value,
	// write the shifted rows back, and classify the position.
	logic [PIX_W-1:0]  older_px;
	logic [PIX_W-1:0]  newer_px;
	logic [CSUM_W-1:0] colsum;
	logic [WIN_W-1:0]  window;
	logic [PROD_W-1:0] prod;
	logic [CSUM_W-1:0] csum0_q;
	logic [CSUM_W-1:0] csum1_q;
	logic              interior;
	logic              border;
	result_t           inner_res;
	result_t           edge_res;
	push_t             push;

	always_comb begin
		older_px = fwd_s1 ? fwd_data_s1[LINE_DW-1:PIX_W] : line_rd_data[LINE_DW-1:PIX_W];
		newer_px = fwd_s1 ? fwd_data_s1[PIX_W-1:0] : line_rd_data[PIX_W-1:0];
		colsum   = CSUM_W'(older_px) + CSUM_W'(newer_px) + CSUM_W'(pixel_s1);
		window   = WIN_W'(csum0_q) + WIN_W'(csum1_q) + WIN_W'(colsum);
		prod     = PROD_W'(window) * PROD_W'(BLUR_MUL) + PROD_W'(BLUR_RND);
	end

	assign line_wr_data = {newer_px, pixel_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			csum0_q <= '0;
			csum1_q <= '0;
		end else if (valid_s1) begin
			csum0_q <= csum1_q;
			csum1_q <= colsum;
		end
	end

	always_comb begin
		interior = (col_s1 >= CW'(2)) && (col_s1 <= w_last_q)
			&& (row_s1 >= RW'(2)) && (row_s1 <= h_last_q);
		border = (row_s1 == '0) || (row_s1 >= h_last_q)
			|| (col_s1 == '0) || (col_s1 >= w_last_q);

		// The blurred pixel sits one up and one left of the arriving pixel.
		inner_res.out_row      = OUT_ROW_W'(row_s1 - RW'(1));
		inner_res.out_col      = OUT_COL_W'(col_s1 - CW'(1));
		inner_res.value        = prod[16 +: PIX_W];
		inner_res.last_of_item = !border;

		edge_res.out_row      = OUT_ROW_W'(row_s1);
		edge_res.out_col      = OUT_COL_W'(col_s1);
		edge_res.value        = pixel_s1;
		edge_res.last_of_item = 1'b1;

		// When both results come, the blurred pixel goes first.
		push.first  = interior ? inner_res : edge_res;
		push.second = edge_res;
		push.count  = valid_s1 ? (2'(interior) + 2'(border)) : 2'd0;
	end

	// Results wait in a small queue so that input transfers continue while the
	// output side is stalled.
	result_t head_res;

	bb3_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (!out_stall),
		.valid     (out_valid),
		.head_data (head_res),
		.level     (fifo_level)
	);

	assign out_row      = head_res.out_row;
	assign out_col      = head_res.out_col;
	assign value        = head_res.value;
	assign last_of_item = head_res.last_of_item;

	// Forwarding happens only when two consecutive pixels share a column.
	`BB3_ASSERT_IMPL(a_fwd_only_one_column, clk, arst_n, valid_s1 && fwd_s1, w_last_q == '0)
	// The stall accounting keeps the queue from overflowing.
	`BB3_ASSERT_IMPL(a_queue_bound, clk, arst_n, 1'b1, fifo_level <= LEVEL_W'(FIFO_DEPTH))
	// A transfer at or past the last column wraps the column counter.
	`BB3_ASSERT_NEXT(a_col_wrap, clk, arst_n, in_xfer && (col_q >= w_last_q), col_q == '0)

endmodule

[rtl/core/bb3_line_mem.sv]
module bb3_line_mem #(
	parameter int DEPTH = 2048,
	parameter int AW    = 11,
	parameter int DW    = 16
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// A read in the same cycle as a write to that entry returns the old data.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[rtl/core/bb3_out_fifo.sv]
module bb3_out_fifo
	import bb3_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  push_t              push,
	input  logic               pop,
	output logic               valid,
	output result_t            head_data,
	output logic [LEVEL_W-1:0] level
);

	result_t              slot_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   head_q;
	logic [FIFO_AW-1:0]   tail_q;
	logic [FIFO_AW-1:0]   tail_next;
	logic [LEVEL_W-1:0]   level_q;
	logic                 pop_take;

	assign valid     = (level_q != '0);
	assign pop_take  = valid && pop;
	assign tail_next = tail_q + FIFO_AW'(1);
	assign head_data = slot_q[head_q];
	assign level     = level_q;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			slot_q[tail_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			slot_q[tail_next] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			level_q <= '0;
		end else begin
			tail_q  <= tail_q + FIFO_AW'(push.count);
			head_q  <= head_q + FIFO_AW'(pop_take);
			level_q <= level_q + LEVEL_W'(push.count) - LEVEL_W'(pop_take);
		end
	end

endmodule
